>>> hw/rtl/sbc_pkg.sv
package sbc_pkg;

    localparam int COORD_W       = 32;
    localparam int FT_W          = 16;
    localparam int SIZE_W        = 12;
    localparam int FRAC_BITS_DEF = 8;
    localparam int TIME_SHIFT    = 16;

    // edge minus origin, worst case over the whole FRAC_BITS range
    localparam int DIFF_W  = 35;
    localparam int MAG_W   = DIFF_W - 1;
    localparam int NUM_W   = MAG_W + TIME_SHIFT;
    localparam int PROD_W  = COORD_W + FT_W;
    localparam int DMAG_W  = COORD_W - 1;
    localparam int TIME_W  = NUM_W + 2;
    localparam int TABS_W  = NUM_W;
    localparam int TSPLIT_W = TABS_W / 2;
    localparam int PP_W    = (TABS_W - TSPLIT_W) + DMAG_W;
    localparam int MULT_W  = PP_W + TSPLIT_W;
    localparam int MAGC_W  = MULT_W - TIME_SHIFT;
    localparam int VAL_W   = MAGC_W + 1;
    localparam int SUM_W   = VAL_W + 1;

    localparam int PREP_STAGES = 3;
    localparam int DIV_STAGES  = NUM_W;
    localparam int POST_STAGES = 8;
    localparam int NUM_STAGES  = PREP_STAGES + DIV_STAGES + POST_STAGES;
    localparam int NUM_LANES   = 4;

    // lanes: x low edge, x high edge, y low edge, y high edge
    localparam int LANE_XLO = 0;
    localparam int LANE_XHI = 1;
    localparam int LANE_YLO = 2;
    localparam int LANE_YHI = 3;

    // endless slab limits; every real slab time stays strictly inside
    localparam logic signed [TIME_W-1:0] T_POS_INF = {2'b01, {(TIME_W-2){1'b0}}};
    localparam logic signed [TIME_W-1:0] T_NEG_INF = {2'b11, {(TIME_W-2){1'b0}}};
    localparam logic signed [TIME_W-1:0] T_ONE =
        {{(TIME_W-TIME_SHIFT-1){1'b0}}, 1'b1, {TIME_SHIFT{1'b0}}};

    localparam logic signed [1:0] NORM_NONE = 2'sb00;
    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [DMAG_W-1:0]         dxm;
        logic [DMAG_W-1:0]         dym;
        logic                      dxneg;
        logic                      dyneg;
        logic                      dxzero;
        logic                      dyzero;
        logic                      vzero;
        logic                      missx;
        logic                      missy;
        logic [NUM_LANES-1:0]      nneg;
    } sbc_side_t;

    typedef struct packed {
        logic [DMAG_W-1:0] rem;
        logic [NUM_W-1:0]  q;
    } sbc_lane_t;

endpackage

>>> hw/rtl/swept_box_collision_test.sv
// Swept box test: each word carries a moving box and a fixed target box and
// yields one result word (hit, entry time, contact point, face normal). A new
// word can enter every cycle while the output is not stalled; the pipeline is made up of
// 3 set-up stages, a 50-stage divider that resolves one quotient bit per
// stage for the four slab times at once, and 8 stages that pick the near
// time and form the contact point. Every stage holds independently, so a
// stalled output only blocks input once the pipeline has filled up.
module swept_box_collision_test import sbc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_origin_x,
    input  logic signed [COORD_W-1:0] s_origin_y,
    input  logic signed [COORD_W-1:0] s_vel_x,
    input  logic signed [COORD_W-1:0] s_vel_y,
    input  logic [FT_W-1:0]           s_frame_time,
    input  logic [SIZE_W-1:0]         s_mover_width,
    input  logic [SIZE_W-1:0]         s_mover_height,
    input  logic signed [COORD_W-1:0] s_target_left,
    input  logic signed [COORD_W-1:0] s_target_top,
    input  logic [SIZE_W-1:0]         s_target_width,
    input  logic [SIZE_W-1:0]         s_target_height,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic signed [COORD_W-1:0] m_hit_time,
    output logic signed [COORD_W-1:0] m_contact_x,
    output logic signed [COORD_W-1:0] m_contact_y,
    output logic signed [1:0]         m_normal_x,
    output logic signed [1:0]         m_normal_y
);

    logic [NUM_STAGES-1:0] v_reg, v_next;
    logic [NUM_STAGES-1:0] en;

    // a stage loads when it is empty or its word moves on
    always_comb begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
                v_next[i] = v_reg[i-1];
            end else begin
                v_next[i] = v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NUM_STAGES-1];

    sbc_side_t        prep_side, div_side;
    logic [NUM_W-1:0] prep_num [NUM_LANES];
    logic [NUM_W-1:0] div_q    [NUM_LANES];

    sbc_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .aclk          (aclk),
        .en            (en[PREP_STAGES-1:0]),
        .origin_x      (s_origin_x),
        .origin_y      (s_origin_y),
        .vel_x         (s_vel_x),
        .vel_y         (s_vel_y),
        .frame_time    (s_frame_time),
        .mover_width   (s_mover_width),
        .mover_height  (s_mover_height),
        .target_left   (s_target_left),
        .target_top    (s_target_top),
        .target_width  (s_target_width),
        .target_height (s_target_height),
        .side_o        (prep_side),
        .num_o         (prep_num)
    );

    sbc_div u_div (
        .aclk   (aclk),
        .en     (en[PREP_STAGES +: DIV_STAGES]),
        .side_i (prep_side),
        .num_i  (prep_num),
        .side_o (div_side),
        .q_o    (div_q)
    );

    sbc_post u_post (
        .aclk        (aclk),
        .en          (en[PREP_STAGES + DIV_STAGES +: POST_STAGES]),
        .side_i      (div_side),
        .q_i         (div_q),
        .hit_o       (m_hit),
        .hit_time_o  (m_hit_time),
        .contact_x_o (m_contact_x),
        .contact_y_o (m_contact_y),
        .normal_x_o  (m_normal_x),
        .normal_y_o  (m_normal_y)
    );

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("accepted word did not enter the first stage");

    a_miss_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_hit_time == '0) && (m_contact_x == '0) &&
                              (m_contact_y == '0) && (m_normal_x == NORM_NONE) &&
                              (m_normal_y == NORM_NONE))
        else $error("miss result carries non-zero fields");

    a_one_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> (m_normal_x == NORM_NONE) || (m_normal_y == NORM_NONE))
        else $error("normal set on both axes");

    a_time_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_hit_time <= $signed(COORD_W'(T_ONE)))
        else $error("hit reported beyond one frame");

    a_normal_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x != 2'sb10) && (m_normal_y != 2'sb10))
        else $error("invalid normal code");

endmodule

>>> hw/rtl/sbc_prep.sv
module sbc_prep import sbc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic [PREP_STAGES-1:0]    en,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] vel_x,
    input  logic signed [COORD_W-1:0] vel_y,
    input  logic [FT_W-1:0]           frame_time,
    input  logic [SIZE_W-1:0]         mover_width,
    input  logic [SIZE_W-1:0]         mover_height,
    input  logic signed [COORD_W-1:0] target_left,
    input  logic signed [COORD_W-1:0] target_top,
    input  logic [SIZE_W-1:0]         target_width,
    input  logic [SIZE_W-1:0]         target_height,
    output sbc_side_t                 side_o,
    output logic [NUM_W-1:0]          num_o [NUM_LANES]
);

    // stage 1: displacement products, grown edges
    logic [PROD_W-1:0]         s1_prodx_reg, s1_prody_reg;
    logic                      s1_xneg_reg, s1_yneg_reg, s1_vzero_reg;
    logic signed [DIFF_W-1:0]  s1_lox_reg, s1_hix_reg, s1_loy_reg, s1_hiy_reg;
    logic signed [COORD_W-1:0] s1_ox_reg, s1_oy_reg;

    logic [COORD_W-1:0]       vxm, vym;
    logic signed [DIFF_W-1:0] tl_ext, tt_ext, mw_half, mh_half, wx_span, wy_span;

    always_comb begin
        vxm = vel_x[COORD_W-1] ? COORD_W'(-vel_x) : COORD_W'(vel_x);
        vym = vel_y[COORD_W-1] ? COORD_W'(-vel_y) : COORD_W'(vel_y);
        tl_ext  = DIFF_W'(target_left);
        tt_ext  = DIFF_W'(target_top);
        mw_half = $signed(DIFF_W'(mover_width) << (FRAC_BITS - 1));
        mh_half = $signed(DIFF_W'(mover_height) << (FRAC_BITS - 1));
        // high edge = left + (2*tw + mw) half pixels
        wx_span = $signed(((DIFF_W'(target_width) << 1) + DIFF_W'(mover_width))
                          << (FRAC_BITS - 1));
        wy_span = $signed(((DIFF_W'(target_height) << 1) + DIFF_W'(mover_height))
                          << (FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_prodx_reg <= PROD_W'(vxm) * PROD_W'(frame_time);
            s1_prody_reg <= PROD_W'(vym) * PROD_W'(frame_time);
            s1_xneg_reg  <= vel_x[COORD_W-1];
            s1_yneg_reg  <= vel_y[COORD_W-1];
            s1_vzero_reg <= (vel_x == '0) && (vel_y == '0);
            s1_lox_reg   <= tl_ext - mw_half;
            s1_hix_reg   <= tl_ext + wx_span;
            s1_loy_reg   <= tt_ext - mh_half;
            s1_hiy_reg   <= tt_ext + wy_span;
            s1_ox_reg    <= origin_x;
            s1_oy_reg    <= origin_y;
        end
    end

    // stage 2: displacement magnitudes, edge offsets from origin
    logic [DMAG_W-1:0]         s2_dxm_reg, s2_dym_reg;
    logic                      s2_xneg_reg, s2_yneg_reg, s2_vzero_reg;
    logic signed [DIFF_W-1:0]  s2_diff_reg [NUM_LANES];
    logic signed [COORD_W-1:0] s2_ox_reg, s2_oy_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_dxm_reg   <= s1_prodx_reg[TIME_SHIFT +: DMAG_W];
            s2_dym_reg   <= s1_prody_reg[TIME_SHIFT +: DMAG_W];
            s2_xneg_reg  <= s1_xneg_reg;
            s2_yneg_reg  <= s1_yneg_reg;
            s2_vzero_reg <= s1_vzero_reg;
            s2_diff_reg[LANE_XLO] <= s1_lox_reg - DIFF_W'(s1_ox_reg);
            s2_diff_reg[LANE_XHI] <= s1_hix_reg - DIFF_W'(s1_ox_reg);
            s2_diff_reg[LANE_YLO] <= s1_loy_reg - DIFF_W'(s1_oy_reg);
            s2_diff_reg[LANE_YHI] <= s1_hiy_reg - DIFF_W'(s1_oy_reg);
            s2_ox_reg    <= s1_ox_reg;
            s2_oy_reg    <= s1_oy_reg;
        end
    end

    // stage 3: numerator magnitudes, slab miss on a still axis
    sbc_side_t        side_next;
    logic [MAG_W-1:0] mag [NUM_LANES];
    logic             dxz, dyz;

    always_comb begin
        dxz = (s2_dxm_reg == '0);
        dyz = (s2_dym_reg == '0);
        for (int j = 0; j < NUM_LANES; j++) begin
            mag[j] = s2_diff_reg[j][DIFF_W-1] ? MAG_W'(-s2_diff_reg[j])
                                               : MAG_W'(s2_diff_reg[j]);
        end
        side_next.ox     = s2_ox_reg;
        side_next.oy     = s2_oy_reg;
        side_next.dxm    = s2_dxm_reg;
        side_next.dym    = s2_dym_reg;
        side_next.dxneg  = s2_xneg_reg;
        side_next.dyneg  = s2_yneg_reg;
        side_next.dxzero = dxz;
        side_next.dyzero = dyz;
        side_next.vzero  = s2_vzero_reg;
        // origin below the low edge or above the high edge
        side_next.missx  = dxz && ((!s2_diff_reg[LANE_XLO][DIFF_W-1] &&
                                     (s2_diff_reg[LANE_XLO] != '0)) ||
                                    s2_diff_reg[LANE_XHI][DIFF_W-1]);
        side_next.missy  = dyz && ((!s2_diff_reg[LANE_YLO][DIFF_W-1] &&
                                     (s2_diff_reg[LANE_YLO] != '0)) ||
                                    s2_diff_reg[LANE_YHI][DIFF_W-1]);
        for (int j = 0; j < NUM_LANES; j++) begin
            side_next.nneg[j] = s2_diff_reg[j][DIFF_W-1];
        end
    end

    sbc_side_t        s3_side_reg;
    logic [NUM_W-1:0] s3_num_reg [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_side_reg <= side_next;
            for (int j = 0; j < NUM_LANES; j++) begin
                s3_num_reg[j] <= {mag[j], {TIME_SHIFT{1'b0}}};
            end
        end
    end

    assign side_o = s3_side_reg;
    assign num_o  = s3_num_reg;

endmodule

>>> hw/rtl/sbc_div.sv
module sbc_div import sbc_pkg::*; (
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] en,
    input  sbc_side_t             side_i,
    input  logic [NUM_W-1:0]      num_i [NUM_LANES],
    output sbc_side_t             side_o,
    output logic [NUM_W-1:0]      q_o [NUM_LANES]
);

    // restoring division, one quotient bit per stage in each of four lanes
    sbc_side_t side_reg [DIV_STAGES];
    sbc_lane_t lane_reg [DIV_STAGES][NUM_LANES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        sbc_side_t side_in;
        sbc_lane_t lane_in   [NUM_LANES];
        sbc_lane_t lane_next [NUM_LANES];

        if (k == 0) begin : g_first
            always_comb begin
                side_in = side_i;
                for (int j = 0; j < NUM_LANES; j++) begin
                    lane_in[j].rem = '0;
                    lane_in[j].q   = num_i[j];
                end
            end
        end else begin : g_rest
            always_comb begin
                side_in = side_reg[k-1];
                for (int j = 0; j < NUM_LANES; j++) begin
                    lane_in[j] = lane_reg[k-1][j];
                end
            end
        end

        always_comb begin
            logic [DMAG_W:0]   trial;
            logic [DMAG_W-1:0] den;
            logic              ge;
            for (int j = 0; j < NUM_LANES; j++) begin
                den   = (j < LANE_YLO) ? side_in.dxm : side_in.dym;
                trial = {lane_in[j].rem, lane_in[j].q[NUM_W-1]};
                ge    = (trial >= {1'b0, den});
                lane_next[j].rem = ge ? DMAG_W'(trial - {1'b0, den})
                                      : trial[DMAG_W-1:0];
                lane_next[j].q   = {lane_in[j].q[NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                side_reg[k] <= side_in;
                for (int j = 0; j < NUM_LANES; j++) begin
                    lane_reg[k][j] <= lane_next[j];
                end
            end
        end
    end

    assign side_o = side_reg[DIV_STAGES-1];

    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            q_o[j] = lane_reg[DIV_STAGES-1][j].q;
        end
    end

endmodule

>>> hw/rtl/sbc_post.sv
module sbc_post import sbc_pkg::*; (
    input  logic                       aclk,
    input  logic [POST_STAGES-1:0]     en,
    input  sbc_side_t                  side_i,
    input  logic [NUM_W-1:0]           q_i [NUM_LANES],
    output logic                       hit_o,
    output logic signed [COORD_W-1:0]  hit_time_o,
    output logic signed [COORD_W-1:0]  contact_x_o,
    output logic signed [COORD_W-1:0]  contact_y_o,
    output logic signed [1:0]          normal_x_o,
    output logic signed [1:0]          normal_y_o
);

    localparam logic signed [TIME_W-1:0] T_MAX32 =
        {{(TIME_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] T_MIN32 =
        {{(TIME_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] S_MAX32 =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_MIN32 =
        {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    // P1: signed slab times
    sbc_side_t                p1_side_reg;
    logic signed [TIME_W-1:0] p1_t_reg [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p1_side_reg <= side_i;
            for (int j = 0; j < NUM_LANES; j++) begin
                if (side_i.nneg[j] ^ ((j < LANE_YLO) ? side_i.dxneg : side_i.dyneg)) begin
                    p1_t_reg[j] <= -$signed(TIME_W'(q_i[j]));
                end else begin
                    p1_t_reg[j] <= $signed(TIME_W'(q_i[j]));
                end
            end
        end
    end

    // P2: near and far per axis, endless on a still axis
    sbc_side_t                p2_side_reg;
    logic signed [TIME_W-1:0] p2_nx_reg, p2_fx_reg, p2_ny_reg, p2_fy_reg;
    logic                     x_swap, y_swap;

    assign x_swap = p1_t_reg[LANE_XLO] > p1_t_reg[LANE_XHI];
    assign y_swap = p1_t_reg[LANE_YLO] > p1_t_reg[LANE_YHI];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p2_side_reg <= p1_side_reg;
            if (p1_side_reg.dxzero) begin
                p2_nx_reg <= T_NEG_INF;
                p2_fx_reg <= T_POS_INF;
            end else begin
                p2_nx_reg <= x_swap ? p1_t_reg[LANE_XHI] : p1_t_reg[LANE_XLO];
                p2_fx_reg <= x_swap ? p1_t_reg[LANE_XLO] : p1_t_reg[LANE_XHI];
            end
            if (p1_side_reg.dyzero) begin
                p2_ny_reg <= T_NEG_INF;
                p2_fy_reg <= T_POS_INF;
            end else begin
                p2_ny_reg <= y_swap ? p1_t_reg[LANE_YHI] : p1_t_reg[LANE_YLO];
                p2_fy_reg <= y_swap ? p1_t_reg[LANE_YLO] : p1_t_reg[LANE_YHI];
            end
        end
    end

    // P3: combine the axes
    sbc_side_t                p3_side_reg;
    logic signed [TIME_W-1:0] p3_tnear_reg, p3_tfar_reg;
    logic                     p3_sep_reg, p3_xgt_reg, p3_xlt_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            p3_side_reg  <= p2_side_reg;
            p3_tnear_reg <= (p2_nx_reg > p2_ny_reg) ? p2_nx_reg : p2_ny_reg;
            p3_tfar_reg  <= (p2_fx_reg < p2_fy_reg) ? p2_fx_reg : p2_fy_reg;
            p3_sep_reg   <= (p2_nx_reg > p2_fy_reg) || (p2_ny_reg > p2_fx_reg);
            p3_xgt_reg   <= p2_nx_reg > p2_ny_reg;
            p3_xlt_reg   <= p2_nx_reg < p2_ny_reg;
        end
    end

    // P4: hit decision, time magnitude for the contact products
    sbc_side_t                 p4_side_reg;
    logic                      p4_hit_reg, p4_tneg_reg;
    logic [TABS_W-1:0]         p4_tabs_reg;
    logic signed [COORD_W-1:0] p4_htime_reg;
    logic signed [1:0]         p4_nx_reg, p4_ny_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            p4_side_reg <= p3_side_reg;
            p4_hit_reg  <= !p3_side_reg.vzero && !p3_side_reg.missx &&
                           !p3_side_reg.missy && !p3_sep_reg &&
                           !p3_tfar_reg[TIME_W-1] && !(p3_tnear_reg > T_ONE);
            p4_tneg_reg <= p3_tnear_reg[TIME_W-1];
            p4_tabs_reg <= p3_tnear_reg[TIME_W-1] ? TABS_W'(-p3_tnear_reg)
                                                  : TABS_W'(p3_tnear_reg);
            if (p3_tnear_reg > T_MAX32) begin
                p4_htime_reg <= COORD_W'(T_MAX32);
            end else if (p3_tnear_reg < T_MIN32) begin
                p4_htime_reg <= COORD_W'(T_MIN32);
            end else begin
                p4_htime_reg <= COORD_W'(p3_tnear_reg);
            end
            // a corner tie leaves both components at zero
            p4_nx_reg <= p3_xgt_reg ? (p3_side_reg.dxneg ? NORM_POS : NORM_NEG) : NORM_NONE;
            p4_ny_reg <= p3_xlt_reg ? (p3_side_reg.dyneg ? NORM_POS : NORM_NEG) : NORM_NONE;
        end
    end

    // P5: partial products of time by displacement
    sbc_side_t                 p5_side_reg;
    logic                      p5_hit_reg, p5_tneg_reg;
    logic signed [COORD_W-1:0] p5_htime_reg;
    logic signed [1:0]         p5_nx_reg, p5_ny_reg;
    logic [PP_W-1:0]           p5_pxl_reg, p5_pxh_reg, p5_pyl_reg, p5_pyh_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            p5_side_reg  <= p4_side_reg;
            p5_hit_reg   <= p4_hit_reg;
            p5_tneg_reg  <= p4_tneg_reg;
            p5_htime_reg <= p4_htime_reg;
            p5_nx_reg    <= p4_nx_reg;
            p5_ny_reg    <= p4_ny_reg;
            p5_pxl_reg   <= PP_W'(p4_tabs_reg[TSPLIT_W-1:0]) * PP_W'(p4_side_reg.dxm);
            p5_pxh_reg   <= PP_W'(p4_tabs_reg[TABS_W-1:TSPLIT_W]) * PP_W'(p4_side_reg.dxm);
            p5_pyl_reg   <= PP_W'(p4_tabs_reg[TSPLIT_W-1:0]) * PP_W'(p4_side_reg.dym);
            p5_pyh_reg   <= PP_W'(p4_tabs_reg[TABS_W-1:TSPLIT_W]) * PP_W'(p4_side_reg.dym);
        end
    end

    // P6: sum the partials, drop the time fraction
    sbc_side_t                 p6_side_reg;
    logic                      p6_hit_reg, p6_sx_reg, p6_sy_reg;
    logic signed [COORD_W-1:0] p6_htime_reg;
    logic signed [1:0]         p6_nx_reg, p6_ny_reg;
    logic [MAGC_W-1:0]         p6_mx_reg, p6_my_reg;
    logic [MULT_W-1:0]         px_full, py_full;

    assign px_full = (MULT_W'(p5_pxh_reg) << TSPLIT_W) + MULT_W'(p5_pxl_reg);
    assign py_full = (MULT_W'(p5_pyh_reg) << TSPLIT_W) + MULT_W'(p5_pyl_reg);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            p6_side_reg  <= p5_side_reg;
            p6_hit_reg   <= p5_hit_reg;
            p6_htime_reg <= p5_htime_reg;
            p6_nx_reg    <= p5_nx_reg;
            p6_ny_reg    <= p5_ny_reg;
            p6_sx_reg    <= p5_tneg_reg ^ p5_side_reg.dxneg;
            p6_sy_reg    <= p5_tneg_reg ^ p5_side_reg.dyneg;
            p6_mx_reg    <= px_full[MULT_W-1:TIME_SHIFT];
            p6_my_reg    <= py_full[MULT_W-1:TIME_SHIFT];
        end
    end

    // P7: apply the sign, truncation toward zero is already in the magnitude
    sbc_side_t                 p7_side_reg;
    logic                      p7_hit_reg;
    logic signed [COORD_W-1:0] p7_htime_reg;
    logic signed [1:0]         p7_nx_reg, p7_ny_reg;
    logic signed [VAL_W-1:0]   p7_vx_reg, p7_vy_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            p7_side_reg  <= p6_side_reg;
            p7_hit_reg   <= p6_hit_reg;
            p7_htime_reg <= p6_htime_reg;
            p7_nx_reg    <= p6_nx_reg;
            p7_ny_reg    <= p6_ny_reg;
            p7_vx_reg    <= p6_sx_reg ? -$signed({1'b0, p6_mx_reg}) : $signed({1'b0, p6_mx_reg});
            p7_vy_reg    <= p6_sy_reg ? -$signed({1'b0, p6_my_reg}) : $signed({1'b0, p6_my_reg});
        end
    end

    // P8: add the origin, saturate, clear everything on a miss
    logic signed [SUM_W-1:0]   sx, sy;
    logic signed [COORD_W-1:0] cx, cy;

    always_comb begin
        sx = SUM_W'(p7_side_reg.ox) + SUM_W'(p7_vx_reg);
        sy = SUM_W'(p7_side_reg.oy) + SUM_W'(p7_vy_reg);
        if (p7_side_reg.dxzero)  cx = p7_side_reg.ox;
        else if (sx > S_MAX32)   cx = COORD_W'(S_MAX32);
        else if (sx < S_MIN32)   cx = COORD_W'(S_MIN32);
        else                     cx = COORD_W'(sx);
        if (p7_side_reg.dyzero)  cy = p7_side_reg.oy;
        else if (sy > S_MAX32)   cy = COORD_W'(S_MAX32);
        else if (sy < S_MIN32)   cy = COORD_W'(S_MIN32);
        else                     cy = COORD_W'(sy);
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            hit_o       <= p7_hit_reg;
            hit_time_o  <= p7_hit_reg ? p7_htime_reg : '0;
            contact_x_o <= p7_hit_reg ? cx : '0;
            contact_y_o <= p7_hit_reg ? cy : '0;
            normal_x_o  <= p7_hit_reg ? p7_nx_reg : NORM_NONE;
            normal_y_o  <= p7_hit_reg ? p7_ny_reg : NORM_NONE;
        end
    end

endmodule
